// ===== design/obbsat_pkg.sv =====
`default_nettype none

package obbsat_pkg;

    localparam int COMP_W  = 21;
    localparam int FRAC_W  = 19;
    localparam int FIELD_W = 63;
    localparam int EPS_W   = 8;
    localparam int DIFF_W  = COMP_W + 1;
    localparam int PROD_W  = DIFF_W + COMP_W;
    localparam int SUM_W   = PROD_W + 3;
    localparam int R_W     = SUM_W - FRAC_W;
    localparam int AR_W    = R_W + 1;
    localparam int PE_W    = COMP_W + AR_W;
    localparam int PT_W    = R_W + R_W;
    localparam int WIDE_W  = 56;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [R_W-1:0]    rval_t;
    typedef logic signed [AR_W-1:0]   arval_t;
    typedef comp_t  vec3_t [3];
    typedef rval_t  rvec_t [3];
    typedef rval_t  rmat_t [3][3];
    typedef arval_t armat_t [3][3];

    function automatic vec3_t unpack3(input logic [FIELD_W-1:0] f);
        vec3_t v;
        for (int k = 0; k < 3; k++)
        begin
            v[k] = comp_t'(f[k*COMP_W +: COMP_W]);
        end
        return v;
    endfunction

    // round half up, then floor shift
    function automatic rval_t rnd(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] v;
        v = s + (SUM_W'(1) <<< (FRAC_W - 1));
        return rval_t'(v >>> FRAC_W);
    endfunction

endpackage

`default_nettype wire

// ===== design/obb_pair_overlap_test.sv =====
// Oriented box pair overlap test, fifteen separating axes.
// Input channel: in_valid / in_stall, one box pair per word, each field a
// packed x,y,z triple of signed 21-bit components.
// Output channel: out_valid / out_stall, one colliding bit per input word.
// Config channel: cfg_valid / cfg_ready / cfg_data writes axis_epsilon;
// cfg_ready is always high. Write only while the pipeline is empty.
// Throughput: one word per cycle unless the output stalls. Stages: axis
// and offset products, dot sums with rounding and |R| + epsilon, radius
// and distance products, sums and compares into the output register.
// The whole pipeline holds while out_valid is high and out_stall is high;
// in_stall follows that condition, so no word is lost or repeated.
// Reset clears all valid bits and sets axis_epsilon to 1.
`default_nettype none

module obb_pair_overlap_test (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  center_a,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  half_a,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_a_x,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_a_y,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_a_z,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  center_b,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  half_b,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_b_x,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_b_y,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_b_z,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 colliding,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [obbsat_pkg::EPS_W-1:0]    cfg_data
);
    import obbsat_pkg::*;

    logic advance;
    logic v1_reg, v2_reg, v3_reg, ov_reg;
    logic [EPS_W-1:0] eps_reg;
    logic col_reg;

    rmat_t  r;
    armat_t ar;
    rvec_t  t;
    vec3_t  ea, eb;

    logic signed [PE_W-1:0] pea_reg [3][3][3];
    logic signed [PE_W-1:0] peb_reg [3][3][3];
    logic signed [PT_W-1:0] pt_reg [3][3][3];
    rvec_t t3_reg;
    vec3_t ea3_reg, eb3_reg;

    logic sep_c;

    assign advance   = !ov_reg || !out_stall;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            eps_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            ov_reg <= v3_reg;
        end
    end

    obbsat_frame u_frame (
        .clk      (clk),
        .en       (advance),
        .center_a (center_a),
        .half_a   (half_a),
        .axis_a_x (axis_a_x),
        .axis_a_y (axis_a_y),
        .axis_a_z (axis_a_z),
        .center_b (center_b),
        .half_b   (half_b),
        .axis_b_x (axis_b_x),
        .axis_b_y (axis_b_y),
        .axis_b_z (axis_b_z),
        .eps      (eps_reg),
        .r        (r),
        .ar       (ar),
        .t        (t),
        .ea       (ea),
        .eb       (eb)
    );

    // p[m][i][j] = factor[m] * matrix[i][j]
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int m = 0; m < 3; m++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        pea_reg[m][i][j] <= PE_W'(ea[m]) * PE_W'(ar[i][j]);
                        peb_reg[m][i][j] <= PE_W'(eb[m]) * PE_W'(ar[i][j]);
                        pt_reg[m][i][j]  <= PT_W'(t[m]) * PT_W'(r[i][j]);
                    end
                end
            end
            t3_reg  <= t;
            ea3_reg <= ea;
            eb3_reg <= eb;
        end
    end

    always_comb
    begin
        logic signed [WIDE_W-1:0] lhs, rhs, dd;
        int i1, i2, j1, j2;
        sep_c = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lhs = WIDE_W'(t3_reg[i]);
            lhs = (lhs < 0) ? -lhs : lhs;
            lhs = lhs <<< FRAC_W;
            rhs = (WIDE_W'(ea3_reg[i]) <<< FRAC_W) + WIDE_W'(peb_reg[0][i][0])
                  + WIDE_W'(peb_reg[1][i][1]) + WIDE_W'(peb_reg[2][i][2]);
            if (lhs > rhs)
            begin
                sep_c = 1'b1;
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            dd = WIDE_W'(pt_reg[0][0][j]) + WIDE_W'(pt_reg[1][1][j])
                 + WIDE_W'(pt_reg[2][2][j]);
            dd = (dd < 0) ? -dd : dd;
            rhs = WIDE_W'(pea_reg[0][0][j]) + WIDE_W'(pea_reg[1][1][j])
                  + WIDE_W'(pea_reg[2][2][j]) + (WIDE_W'(eb3_reg[j]) <<< FRAC_W);
            if (dd > rhs)
            begin
                sep_c = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j == 2) ? 0 : j + 1;
                j2 = (j == 0) ? 2 : j - 1;
                dd = WIDE_W'(pt_reg[i2][i1][j]) - WIDE_W'(pt_reg[i1][i2][j]);
                dd = (dd < 0) ? -dd : dd;
                rhs = WIDE_W'(pea_reg[i1][i2][j]) + WIDE_W'(pea_reg[i2][i1][j])
                      + WIDE_W'(peb_reg[j1][i][j2]) + WIDE_W'(peb_reg[j2][i][j1]);
                if (dd > rhs)
                begin
                    sep_c = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col_reg <= !sep_c;
        end
    end

    assign out_valid = ov_reg;
    assign colliding = col_reg;

endmodule

`default_nettype wire

// ===== design/obbsat_frame.sv =====
`default_nettype none

module obbsat_frame (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  center_a,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  half_a,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_a_x,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_a_y,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_a_z,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  center_b,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  half_b,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_b_x,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_b_y,
    input  wire logic [obbsat_pkg::FIELD_W-1:0]  axis_b_z,
    input  wire logic [obbsat_pkg::EPS_W-1:0]    eps,
    output obbsat_pkg::rmat_t                    r,
    output obbsat_pkg::armat_t                   ar,
    output obbsat_pkg::rvec_t                    t,
    output obbsat_pkg::vec3_t                    ea,
    output obbsat_pkg::vec3_t                    eb
);
    import obbsat_pkg::*;

    vec3_t ca, cb, ha, hb;
    vec3_t a [3];
    vec3_t b [3];
    logic signed [DIFF_W-1:0] d_c [3];

    logic signed [PROD_W-1:0] pab_reg [3][3][3];
    logic signed [PROD_W-1:0] pd_reg [3][3];
    vec3_t ea1_reg, eb1_reg;

    rmat_t  r_reg;
    armat_t ar_reg;
    rvec_t  t_reg;
    vec3_t  ea2_reg, eb2_reg;

    rmat_t  r_next;
    armat_t ar_next;
    rvec_t  t_next;

    always_comb
    begin
        ca   = unpack3(center_a);
        cb   = unpack3(center_b);
        ha   = unpack3(half_a);
        hb   = unpack3(half_b);
        a[0] = unpack3(axis_a_x);
        a[1] = unpack3(axis_a_y);
        a[2] = unpack3(axis_a_z);
        b[0] = unpack3(axis_b_x);
        b[1] = unpack3(axis_b_y);
        b[2] = unpack3(axis_b_z);
        for (int k = 0; k < 3; k++)
        begin
            d_c[k] = DIFF_W'(cb[k]) - DIFF_W'(ca[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pd_reg[i][k] <= PROD_W'(d_c[k]) * PROD_W'(a[i][k]);
                    for (int j = 0; j < 3; j++)
                    begin
                        pab_reg[i][j][k] <= PROD_W'(a[i][k]) * PROD_W'(b[j][k]);
                    end
                end
            end
            ea1_reg <= ha;
            eb1_reg <= hb;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_next[i] = rnd(SUM_W'(pd_reg[i][0]) + SUM_W'(pd_reg[i][1])
                            + SUM_W'(pd_reg[i][2]));
            for (int j = 0; j < 3; j++)
            begin
                r_next[i][j] = rnd(SUM_W'(pab_reg[i][j][0]) + SUM_W'(pab_reg[i][j][1])
                                   + SUM_W'(pab_reg[i][j][2]));
                ar_next[i][j] = (r_next[i][j][R_W-1] ? -AR_W'(r_next[i][j])
                                                     : AR_W'(r_next[i][j]))
                                + $signed({{(AR_W-EPS_W){1'b0}}, eps});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            ar_reg  <= ar_next;
            t_reg   <= t_next;
            ea2_reg <= ea1_reg;
            eb2_reg <= eb1_reg;
        end
    end

    assign r  = r_reg;
    assign ar = ar_reg;
    assign t  = t_reg;
    assign ea = ea2_reg;
    assign eb = eb2_reg;

endmodule

`default_nettype wire

// ===== design/obbsat_checker.sv =====
`default_nettype none

module obbsat_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
        ##1 !out_stall |=> out_valid)
        else $error("accepted word did not reach the output");

    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall || !out_valid |-> !in_stall)
        else $error("input stalled with free output");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind obb_pair_overlap_test obbsat_checker u_obbsat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import obbsat_pkg::*;

    typedef logic [FIELD_W-1:0] pair_t [10];

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [FIELD_W-1:0] fld [10];
    logic out_valid;
    logic out_stall;
    logic colliding;
    logic cfg_valid;
    logic cfg_ready;
    logic [EPS_W-1:0] cfg_data;

    logic [EPS_W-1:0] eps_model;
    bit overlap_q [$];
    int errors;
    bit send_idle;
    bit recv_idle;

    obb_pair_overlap_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .center_a  (fld[0]),
        .half_a    (fld[1]),
        .axis_a_x  (fld[2]),
        .axis_a_y  (fld[3]),
        .axis_a_z  (fld[4]),
        .center_b  (fld[5]),
        .half_b    (fld[6]),
        .axis_b_x  (fld[7]),
        .axis_b_y  (fld[8]),
        .axis_b_z  (fld[9]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .colliding (colliding),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("[obb_pair_overlap_test] ERROR");
        $finish;
    end

    function automatic longint comp(input logic [FIELD_W-1:0] f, input int k);
        comp_t c;
        c = f[k*COMP_W +: COMP_W];
        return longint'(c);
    endfunction

    function automatic longint rnd_shift(input longint s);
        return (s + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic longint mag(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic bit boxes_overlap(input pair_t p, input logic [EPS_W-1:0] eps);
        longint ca[3], cb[3], ea[3], eb[3], a[3][3], b[3][3];
        longint r[3][3], ar[3][3], t[3];
        longint one, s, ra, rb, d;
        int i1, i2, j1, j2;
        bit sep;
        one = longint'(1) <<< FRAC_W;
        sep = 0;
        for (int k = 0; k < 3; k++)
        begin
            ca[k] = comp(p[0], k);
            ea[k] = comp(p[1], k);
            cb[k] = comp(p[5], k);
            eb[k] = comp(p[6], k);
            for (int i = 0; i < 3; i++)
            begin
                a[i][k] = comp(p[2+i], k);
                b[i][k] = comp(p[7+i], k);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s = 0;
                for (int k = 0; k < 3; k++)
                    s += a[i][k] * b[j][k];
                r[i][j] = rnd_shift(s);
                ar[i][j] = mag(r[i][j]) + longint'(eps);
            end
            s = 0;
            for (int k = 0; k < 3; k++)
                s += (cb[k] - ca[k]) * a[i][k];
            t[i] = rnd_shift(s);
        end
        for (int i = 0; i < 3; i++)
        begin
            rb = eb[0] * ar[i][0] + eb[1] * ar[i][1] + eb[2] * ar[i][2];
            if (mag(t[i]) * one > ea[i] * one + rb)
                sep = 1;
        end
        for (int j = 0; j < 3; j++)
        begin
            ra = ea[0] * ar[0][j] + ea[1] * ar[1][j] + ea[2] * ar[2][j];
            d = t[0] * r[0][j] + t[1] * r[1][j] + t[2] * r[2][j];
            if (mag(d) > ra + eb[j] * one)
                sep = 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++)
            begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                ra = ea[i1] * ar[i2][j] + ea[i2] * ar[i1][j];
                rb = eb[j1] * ar[i][j2] + eb[j2] * ar[i][j1];
                d = t[i2] * r[i1][j] - t[i1] * r[i2][j];
                if (mag(d) > ra + rb)
                    sep = 1;
            end
        end
        return !sep;
    endfunction

    function automatic logic [FIELD_W-1:0] pack3(input longint x, input longint y,
                                                 input longint z);
        return {z[COMP_W-1:0], y[COMP_W-1:0], x[COMP_W-1:0]};
    endfunction

    function automatic logic [FIELD_W-1:0] rand_field();
        return FIELD_W'({$urandom, $urandom});
    endfunction

    function automatic longint q_axis(input real v);
        return longint'($rtoi(v * 524288.0 + (v < 0 ? -0.5 : 0.5)));
    endfunction

    // rotation from three random angles (sometimes a lone yaw in right angles), rows written as box axes
    task automatic rand_axes(output logic [FIELD_W-1:0] ax [3]);
        real y, pt, rl, cy, sy, cp, sp, cr, sr;
        real m [3][3];
        y = $urandom_range(0, 62831) / 10000.0;
        pt = $urandom_range(0, 62831) / 10000.0;
        rl = $urandom_range(0, 62831) / 10000.0;
        if ($urandom_range(0, 5) == 0)
        begin
            y = $urandom_range(0, 3) * 1.5707963;
            pt = 0.0;
            rl = 0.0;
        end
        cy = $cos(y); sy = $sin(y);
        cp = $cos(pt); sp = $sin(pt);
        cr = $cos(rl); sr = $sin(rl);
        m[0][0] = cy * cp; m[0][1] = sy * cp; m[0][2] = -sp;
        m[1][0] = cy * sp * sr - sy * cr; m[1][1] = sy * sp * sr + cy * cr;
        m[1][2] = cp * sr;
        m[2][0] = cy * sp * cr + sy * sr; m[2][1] = sy * sp * cr - cy * sr;
        m[2][2] = cp * cr;
        for (int i = 0; i < 3; i++)
            ax[i] = pack3(q_axis(m[i][0]), q_axis(m[i][1]), q_axis(m[i][2]));
    endtask

    task automatic rand_pair(output pair_t p);
        logic [FIELD_W-1:0] ax [3];
        longint sz;
        if ($urandom_range(0, 9) == 0)
        begin
            for (int i = 0; i < 10; i++)
                p[i] = rand_field();
            return;
        end
        sz = $urandom_range(0, 3) == 0 ? 40000 : 4000;
        p[0] = pack3($urandom_range(0, 2*sz) - sz, $urandom_range(0, 2*sz) - sz,
                     $urandom_range(0, 2*sz) - sz);
        p[5] = pack3(comp(p[0], 0) + $urandom_range(0, 2*sz) - sz,
                     comp(p[0], 1) + $urandom_range(0, 2*sz) - sz,
                     comp(p[0], 2) + $urandom_range(0, 2*sz) - sz);
        p[1] = pack3($urandom_range(1, sz/2), $urandom_range(1, sz/2),
                     $urandom_range(1, sz/2));
        p[6] = pack3($urandom_range(1, sz/2), $urandom_range(1, sz/2),
                     $urandom_range(1, sz/2));
        rand_axes(ax);
        for (int i = 0; i < 3; i++)
            p[2+i] = ax[i];
        rand_axes(ax);
        for (int i = 0; i < 3; i++)
            p[7+i] = ax[i];
    endtask

    task automatic send_pair(input pair_t p);
        if (send_idle && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        for (int i = 0; i < 10; i++)
            fld[i] <= p[i];
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        overlap_q.push_back(boxes_overlap(p, eps_model));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (overlap_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_epsilon(input logic [EPS_W-1:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        eps_model = v;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (overlap_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %0b", $time, colliding);
                errors++;
            end
            else if (overlap_q[0] !== colliding)
            begin
                $display("%0t: colliding mismatch, expected %0b, actual %0b",
                         $time, overlap_q[0], colliding);
                errors++;
                void'(overlap_q.pop_front());
            end
            else
                void'(overlap_q.pop_front());
        end
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_idle && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // axis-aligned boxes, B offset along x by the sum of half widths plus extra
    task automatic touch_pair(input longint extra, input longint ha, input longint hb);
        pair_t p;
        p[0] = pack3(100, -50, 25);
        p[1] = pack3(ha, 300, 300);
        p[2] = pack3(1 << FRAC_W, 0, 0);
        p[3] = pack3(0, 1 << FRAC_W, 0);
        p[4] = pack3(0, 0, 1 << FRAC_W);
        p[5] = pack3(100 + ha + hb + extra, -50, 25);
        p[6] = pack3(hb, 200, 200);
        for (int i = 0; i < 3; i++)
            p[7+i] = p[2+i];
        send_pair(p);
    endtask

    task automatic test_directed();
        pair_t p;
        for (int i = 0; i < 10; i++)
            p[i] = '0;
        send_pair(p);
        for (int i = 0; i < 10; i++)
            p[i] = '1;
        send_pair(p);
        for (int i = 0; i < 10; i++)
            p[i] = pack3(1048575, 1048575, 1048575);
        send_pair(p);
        for (int i = 0; i < 10; i++)
            p[i] = pack3(-1048576, -1048576, -1048576);
        send_pair(p);
        for (int i = 0; i < 10; i++)
            p[i] = i[0] ? pack3(1048575, -1048576, 1048575) : pack3(-1048576, 1048575, 0);
        send_pair(p);
        touch_pair(-1, 500, 700);
        touch_pair(0, 500, 700);
        touch_pair(1, 500, 700);
        touch_pair(0, -400, 300);
        touch_pair(-900, -400, -300);
        rand_pair(p);
        p[7] = '0;
        p[8] = '0;
        p[9] = '0;
        send_pair(p);
        rand_pair(p);
        p[2] = pack3(3 << FRAC_W, 0, 0);
        p[5] = p[0];
        send_pair(p);
        drain();
        write_epsilon(8'd0);
        touch_pair(-1, 500, 700);
        touch_pair(0, 500, 700);
        touch_pair(1, 500, 700);
        touch_pair(0, 1048575, 1048575);
        write_epsilon(8'd255);
        touch_pair(0, 500, 700);
        touch_pair(1, 500, 700);
        for (int i = 0; i < 4; i++)
        begin
            rand_pair(p);
            send_pair(p);
        end
    endtask

    task automatic test_random(input int n);
        pair_t p;
        for (int i = 0; i < n; i++)
        begin
            rand_pair(p);
            send_pair(p);
            if (i == n / 2)
                drain();
        end
    endtask

    task automatic test_epsilon_sweep();
        logic [EPS_W-1:0] vals [4];
        vals = '{8'd0, 8'd255, 8'hAA, 8'h55};
        foreach (vals[v])
        begin
            write_epsilon(vals[v]);
            test_random(250);
        end
        write_epsilon(EPS_W'($urandom_range(0, 255)));
        test_random(250);
    endtask

    task automatic test_full_rate();
        send_idle = 0;
        recv_idle = 0;
        write_epsilon(8'd1);
        test_random(400);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < 10; i++)
            fld[i] = '0;
        eps_model = 8'd1;
        errors = 0;
        send_idle = 1;
        recv_idle = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(250);
        test_epsilon_sweep();
        test_full_rate();
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("[obb_pair_overlap_test] OK");
        else
            $display("[obb_pair_overlap_test] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/obbsat_pkg.sv
design/obbsat_frame.sv
design/obb_pair_overlap_test.sv
design/obbsat_checker.sv
sim/tb_top.sv
